// ===== rtl/core/sscr_pkg.sv =====
// Shared types and constants for the scatter sub-cell rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package sscr_pkg;

  localparam int COORD_W   = 32;
  localparam int IDX_W     = 13;
  localparam int MASK_W    = 6;
  localparam int CFG_IDX_W = 3;

  // Commands
  localparam logic CMD_PLOT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LOWER   = 3'd0,
    CFG_X_UPPER   = 3'd1,
    CFG_Y_LOWER   = 3'd2,
    CFG_Y_UPPER   = 3'd3,
    CFG_GRID_COLS = 3'd4,
    CFG_GRID_ROWS = 3'd5
  } cfg_idx_t;

  // Register reset values
  localparam logic [COORD_W-1:0] X_LOWER_RST = 32'h0000_0000;
  localparam logic [COORD_W-1:0] X_UPPER_RST = 32'h0001_0000;
  localparam logic [COORD_W-1:0] Y_LOWER_RST = 32'h0000_0000;
  localparam logic [COORD_W-1:0] Y_UPPER_RST = 32'h0001_0000;
  localparam int GRID_COLS_RST = 80;
  localparam int GRID_ROWS_RST = 24;

  typedef struct packed {
    logic                      command;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [IDX_W-1:0]          cell_index;
  } in_t;

  typedef struct packed {
    logic [MASK_W-1:0] cell_mask;
    logic              in_range;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/core/sscr_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sscr_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 8192
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/sscr_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, quotient known < 2**QW.
`timescale 1ns / 1ps
`default_nettype none
module sscr_div #(
  parameter int QW = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [sscr_pkg::COORD_W+QW-1:0]      num,
  input  wire logic [sscr_pkg::COORD_W-1:0]         den,
  output logic                                      done,
  output logic      [QW-1:0]                        quo
);
  import sscr_pkg::*;

  localparam int CNT_W = $clog2(QW + 1);

  logic [COORD_W-1:0] rem_r;
  logic [COORD_W-1:0] den_r;
  logic [QW-1:0]      lo_r;
  logic [QW-1:0]      quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [COORD_W:0]   trial;
  logic [COORD_W:0]   diff;
  logic               ge;

  always_comb begin
    trial = {rem_r, lo_r[QW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulses on the last quotient bit
      done_r <= busy_r && !start && (cnt_r == CNT_W'(1));
      if (start) begin
        // top part of the numerator is already below the divisor
        rem_r  <= num[COORD_W+QW-1:QW];
        lo_r   <= num[QW-1:0];
        den_r  <= den;
        quo_r  <= '0;
        cnt_r  <= CNT_W'(QW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
        lo_r  <= lo_r << 1;
        quo_r <= QW'({quo_r, ge});
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== rtl/core/scatter_subcell_rasterizer.sv =====
// Top level of the scatter sub-cell rasterizer: control, config and cell store.
// Plot: check, x then y numerator and bit-serial divide (QW quotient bits each,
//   QW = max(clog2(2*MAX_COLS), clog2(3*MAX_ROWS)), 8 at defaults), split, flip,
//   address, memory read, write-back, output load. Read: check, memory read,
//   write-back, output load. One item at a time. Reset (rst_n, sync): registers take
//   reset values; a pass zeroes the MAX_COLS*MAX_ROWS (8192) cells; no input then.
`timescale 1ns / 1ps
`default_nettype none
module scatter_subcell_rasterizer #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire sscr_pkg::in_t                     in_data,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output sscr_pkg::out_t                         out_data,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sscr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sscr_pkg::COORD_W-1:0]      cfg_data
);
  import sscr_pkg::*;

  // Store geometry
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Clamped grid dimension widths
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  // Fine coordinate widths: fine_x < 2*cols, fine_y < 3*rows
  localparam int QWX   = $clog2(2 * MAX_COLS);
  localparam int QWY   = $clog2(3 * MAX_ROWS);
  localparam int QW    = (QWX > QWY) ? QWX : QWY;
  localparam int NW    = COORD_W + QW;
  localparam int SW    = QWY + CW + 1;
  // Divide-by-3 through a reciprocal: exact for fine_y < 2**(DIV3_SH-1)
  localparam int DIV3_SH = QWY + 1 + ((QWY + 1) % 2);
  localparam int DIV3_M  = ((1 << DIV3_SH) + 2) / 3;
  localparam logic [DIV3_SH-1:0] DIV3_MV = DIV3_SH'(DIV3_M);

  localparam int COLS_RST = (MAX_COLS < GRID_COLS_RST) ? MAX_COLS : GRID_COLS_RST;
  localparam int ROWS_RST = (MAX_ROWS < GRID_ROWS_RST) ? MAX_ROWS : GRID_ROWS_RST;

  typedef enum logic [3:0] {
    S_CLEAR,   // zero the store after reset
    S_IDLE,    // take the next transaction
    S_CHECK,   // bounds test, offsets and spans
    S_MULX,    // numerator for x, start divider
    S_DIVX,
    S_MULY,
    S_DIVY,
    S_SPLIT,   // fine_y / 3 by reciprocal
    S_FLIP,    // top origin, sub-block bit
    S_ADDR,    // row*cols + col
    S_RD,      // memory read
    S_WR,      // modify and write back
    S_OUT      // load the output register
  } state_t;

  state_t state_r;

  // Configuration
  logic signed [COORD_W-1:0] xl_r, xu_r, yl_r, yu_r;
  logic [CW-1:0]             cols_r;
  logic [RW-1:0]             rows_r;

  // Datapath registers
  in_t                item_r;
  logic [COORD_W-1:0] dx_r, dy_r, sx_r, sy_r;
  logic [NW-1:0]      num_r;
  logic               div_go_r;
  logic [QWX-1:0]     fx_r;
  logic [QWY-1:0]     fy_r;
  logic [QWY-1:0]     row_q_r;
  logic [QWY-1:0]     row_f_r;
  logic [2:0]         bitpos_r;
  logic [AW-1:0]      addr_r;
  logic [AW-1:0]      clr_addr_r;
  out_t               res_r;
  out_t               out_data_r;
  logic               out_valid_r;

  // Combinational helpers
  logic [CW-1:0]            cols_cfg;
  logic [RW-1:0]            rows_cfg;
  logic [7:0]               gc;
  logic [6:0]               gr;
  logic signed [COORD_W:0]  dx_full, dy_full, sx_full, sy_full;
  logic                     in_bounds;
  logic [CW:0]              cols2;
  logic [RW+1:0]            rows3;
  logic [COORD_W+CW:0]      prod_x;
  logic [COORD_W+RW+1:0]    prod_y;
  logic [QWY+DIV3_SH-1:0]   prod3;
  logic [QWY-1:0]           t3;
  logic [QWY-1:0]           rem3;
  logic [1:0]               subr;
  logic [1:0]               subr_f;
  logic [SW-1:0]            cell_sum;
  logic                     idx_ok;

  // Divider and memory hookup
  logic               div_done;
  logic [QW-1:0]      div_quo;
  logic [COORD_W-1:0] div_den;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [MASK_W-1:0]  mem_wdata;
  logic [MASK_W-1:0]  mem_rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Grid sizes are clamped to [1, MAX] as they are written
  always_comb begin
    gc = cfg_data[7:0];
    gr = cfg_data[6:0];
    if (gc == 8'd0) begin
      cols_cfg = CW'(1);
    end else if ({24'd0, gc} > 32'(MAX_COLS)) begin
      cols_cfg = CW'(MAX_COLS);
    end else begin
      cols_cfg = CW'(gc);
    end
    if (gr == 7'd0) begin
      rows_cfg = RW'(1);
    end else if ({25'd0, gr} > 32'(MAX_ROWS)) begin
      rows_cfg = RW'(MAX_ROWS);
    end else begin
      rows_cfg = RW'(gr);
    end
  end

  always_comb begin
    // bounds: [lower, upper) on both axes; an empty span rejects everything
    in_bounds = (item_r.x_coord >= xl_r) && (item_r.x_coord < xu_r) &&
                (item_r.y_coord >= yl_r) && (item_r.y_coord < yu_r);
    dx_full = {item_r.x_coord[COORD_W-1], item_r.x_coord} - {xl_r[COORD_W-1], xl_r};
    dy_full = {item_r.y_coord[COORD_W-1], item_r.y_coord} - {yl_r[COORD_W-1], yl_r};
    sx_full = {xu_r[COORD_W-1], xu_r} - {xl_r[COORD_W-1], xl_r};
    sy_full = {yu_r[COORD_W-1], yu_r} - {yl_r[COORD_W-1], yl_r};
    idx_ok  = ({19'd0, item_r.cell_index} < 32'(DEPTH));

    cols2   = {cols_r, 1'b0};
    rows3   = {1'b0, rows_r, 1'b0} + {2'b00, rows_r};
    prod_x  = dx_r * cols2;
    prod_y  = dy_r * rows3;

    prod3   = fy_r * DIV3_MV;
    t3      = QWY'({row_q_r, 1'b0}) + row_q_r;
    rem3    = fy_r - t3;
    subr    = rem3[1:0];
    subr_f  = 2'd2 - subr;

    cell_sum = row_f_r * cols_r + (fx_r >> 1);
  end

  assign div_den = (state_r == S_DIVY) ? sy_r : sx_r;

  sscr_div #(
    .QW (QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (num_r),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_r;
    mem_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr_r;
      end
      S_WR: begin
        mem_we = 1'b1;
        if (item_r.command == CMD_PLOT) begin
          mem_wdata = mem_rdata | (MASK_W'(1) << bitpos_r);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  sscr_ram #(
    .WIDTH (MASK_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Control, configuration and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      xl_r        <= X_LOWER_RST;
      xu_r        <= X_UPPER_RST;
      yl_r        <= Y_LOWER_RST;
      yu_r        <= Y_UPPER_RST;
      cols_r      <= CW'(COLS_RST);
      rows_r      <= RW'(ROWS_RST);
    end else begin
      // divider start pulse, in the cycle after each numerator load
      div_go_r <= (state_r == S_MULX) || (state_r == S_MULY);

      // configuration writes are taken in any state
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_X_LOWER:   xl_r   <= cfg_data;
          CFG_X_UPPER:   xu_r   <= cfg_data;
          CFG_Y_LOWER:   yl_r   <= cfg_data;
          CFG_Y_UPPER:   yu_r   <= cfg_data;
          CFG_GRID_COLS: cols_r <= cols_cfg;
          CFG_GRID_ROWS: rows_r <= rows_cfg;
          default: ;
        endcase
      end

      // result taken downstream; S_OUT drives the valid flag itself
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_CHECK;
          end
        end

        S_CHECK: begin
          res_r.cell_mask <= '0;
          res_r.in_range  <= 1'b0;
          addr_r          <= AW'(item_r.cell_index);
          dx_r            <= dx_full[COORD_W-1:0];
          dy_r            <= dy_full[COORD_W-1:0];
          sx_r            <= sx_full[COORD_W-1:0];
          sy_r            <= sy_full[COORD_W-1:0];
          if (item_r.command == CMD_READ) begin
            // index past the store reads as zero and touches nothing
            state_r <= idx_ok ? S_RD : S_OUT;
          end else begin
            state_r <= in_bounds ? S_MULX : S_OUT;
          end
        end

        S_MULX: begin
          num_r    <= NW'(prod_x);
          state_r  <= S_DIVX;
        end

        S_DIVX: begin
          if (div_done) begin
            fx_r    <= div_quo[QWX-1:0];
            state_r <= S_MULY;
          end
        end

        S_MULY: begin
          num_r    <= NW'(prod_y);
          state_r  <= S_DIVY;
        end

        S_DIVY: begin
          if (div_done) begin
            fy_r    <= div_quo[QWY-1:0];
            state_r <= S_SPLIT;
          end
        end

        S_SPLIT: begin
          row_q_r <= prod3[QWY+DIV3_SH-1:DIV3_SH];
          state_r <= S_FLIP;
        end

        S_FLIP: begin
          // flip to top origin, bit = 2*subrow + subcol
          row_f_r  <= QWY'(rows_r) - row_q_r - QWY'(1);
          bitpos_r <= {subr_f, 1'b0} + {2'b00, fx_r[0]};
          state_r  <= S_ADDR;
        end

        S_ADDR: begin
          addr_r  <= AW'(cell_sum);
          state_r <= S_RD;
        end

        S_RD: begin
          state_r <= S_WR;
        end

        S_WR: begin
          // read returns the old mask and clears; plot ORs in its bit
          if (item_r.command == CMD_READ) begin
            res_r.cell_mask <= mem_rdata;
          end else begin
            res_r.in_range  <= 1'b1;
          end
          state_r <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== dv/sscr_cell_checker.sv =====
// Cell store predictor and result comparator for the scatter sub-cell rasterizer.
`timescale 1ns / 1ps
module sscr_cell_checker #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire sscr_pkg::in_t                  in_data,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire sscr_pkg::out_t                 out_data,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [sscr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sscr_pkg::COORD_W-1:0]   cfg_data,
  input  wire logic                           end_check,
  output int                                  fail_count,
  output int                                  pending
);
  import sscr_pkg::*;

  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;

  logic [MASK_W-1:0]         cell_store [STORE_DEPTH];
  logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic [7:0]                cols_reg;
  logic [6:0]                rows_reg;
  out_t                      expected_cells [$];
  bit                        end_seen;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic longint unsigned clamp_dim(input int value, input int maxv);
    if (value < 1) return 1;
    if (value > maxv) return maxv;
    return value;
  endfunction

  // One command against the model store; returns the result it should produce.
  function automatic out_t apply_command(input in_t t);
    out_t            res;
    longint unsigned cols, rows, dx, dy, sx, sy, fx, fy, row, col, cell_no;
    int unsigned     subc, subr;
    res = '0;
    if (t.command == CMD_READ) begin
      if (t.cell_index < STORE_DEPTH) begin
        res.cell_mask = cell_store[t.cell_index];
        cell_store[t.cell_index] = '0;
      end
      return res;
    end
    // bounds are half-open; an empty or inverted span drops every point
    if (t.x_coord < x_lo || t.x_coord >= x_hi || t.y_coord < y_lo || t.y_coord >= y_hi)
      return res;
    cols = clamp_dim(int'(cols_reg), MAX_COLS);
    rows = clamp_dim(int'(rows_reg), MAX_ROWS);
    dx   = longint'(t.x_coord) - longint'(x_lo);
    dy   = longint'(t.y_coord) - longint'(y_lo);
    sx   = longint'(x_hi) - longint'(x_lo);
    sy   = longint'(y_hi) - longint'(y_lo);
    fx   = dx * 2 * cols / sx;
    fy   = dy * 3 * rows / sy;
    col  = fx >> 1;
    subc = int'(fx % 2);
    // flip to a top-left origin
    row  = rows - 1 - fy / 3;
    subr = 2 - int'(fy % 3);
    cell_no = row * cols + col;
    if (cell_no < STORE_DEPTH)
      cell_store[cell_no] = cell_store[cell_no] | MASK_W'(1 << (2 * subr + subc));
    res.in_range = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      x_lo     = X_LOWER_RST;
      x_hi     = X_UPPER_RST;
      y_lo     = Y_LOWER_RST;
      y_hi     = Y_UPPER_RST;
      cols_reg = 8'(GRID_COLS_RST);
      rows_reg = 7'(GRID_ROWS_RST);
      foreach (cell_store[i]) cell_store[i] = '0;
      expected_cells.delete();
      end_seen = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_X_LOWER:   x_lo = cfg_data;
          CFG_X_UPPER:   x_hi = cfg_data;
          CFG_Y_LOWER:   y_lo = cfg_data;
          CFG_Y_UPPER:   y_hi = cfg_data;
          CFG_GRID_COLS: cols_reg = cfg_data[7:0];
          CFG_GRID_ROWS: rows_reg = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_cells.push_back(apply_command(in_data));
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: mask=%0h in_range=%0b",
                                    out_data.cell_mask, out_data.in_range));
        end else begin
          want = expected_cells.pop_front();
          if (out_data.cell_mask !== want.cell_mask)
            report_mismatch($sformatf("cell_mask got %0h want %0h",
                                      out_data.cell_mask, want.cell_mask));
          if (out_data.in_range !== want.in_range)
            report_mismatch($sformatf("in_range got %0b want %0b",
                                      out_data.in_range, want.in_range));
        end
      end
      if (end_check && !end_seen) begin
        end_seen = 1'b1;
        foreach (expected_cells[i])
          report_mismatch($sformatf("no result for transaction, mask=%0h in_range=%0b",
                                    expected_cells[i].cell_mask, expected_cells[i].in_range));
      end
    end
    pending = expected_cells.size();
  end

endmodule

// ===== dv/tb_scatter_subcell_rasterizer.sv =====
// Testbench top for the scatter sub-cell rasterizer: stimulus, sink and verdict.
`timescale 1ns / 1ps
module tb_scatter_subcell_rasterizer;
  import sscr_pkg::*;

  localparam int GRID_MAX_COLS    = 128;
  localparam int GRID_MAX_ROWS    = 64;
  localparam int HALF_PERIOD      = 5;
  // a plot at these sizes finishes well within this; leave margin
  localparam int SETTLE_CYCLES    = 40;
  // drain bound also covers the store clear of 8192 entries after reset
  localparam int DRAIN_LIMIT      = 20000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES    = 10;
  localparam int ITEMS_PER_PHASE  = 78;
  localparam int HOLD_PHASE       = 2;
  localparam int PAUSE_PHASE      = 5;
  localparam int RUN_LIMIT_NS     = 4_000_000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;
  logic                 end_check;
  int                   fail_count;
  int                   pending;

  // stimulus-side copy of the current bounds, used only to aim points and reads
  logic signed [COORD_W-1:0] cur_x_lo, cur_x_hi, cur_y_lo, cur_y_hi;
  int                        cur_cols, cur_rows;

  bit idle_en;        // random gaps on both sides
  bit long_hold_req;  // asks the sink for one long stall

  always #HALF_PERIOD clk = ~clk;

  scatter_subcell_rasterizer #(
    .MAX_COLS (GRID_MAX_COLS),
    .MAX_ROWS (GRID_MAX_ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sscr_cell_checker #(
    .MAX_COLS (GRID_MAX_COLS),
    .MAX_ROWS (GRID_MAX_ROWS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .end_check  (end_check),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // ---------------------------------------------------------------------------
  // Result sink: alternates free-running stretches with stall bursts. A long
  // hold-off, counted here, backs the block up so that in_stall rises.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Handshake signals are sampled at the falling edge, where they
  // are settled, and the transaction counts as taken at the next rising edge.
  // send_txn never lowers in_valid unless it inserts a gap, so back-to-back
  // transactions keep valid high with a single assignment per edge.
  // ---------------------------------------------------------------------------
  task automatic send_txn(input in_t t);
    logic stalled;
    in_valid <= 1'b1;
    in_data  <= t;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic in_t plot_txn(input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] y);
    in_t t;
    t = '0;
    t.command = CMD_PLOT;
    t.x_coord = x;
    t.y_coord = y;
    return t;
  endfunction

  function automatic in_t read_txn(input int idx);
    in_t t;
    t = '0;
    t.command    = CMD_READ;
    t.cell_index = IDX_W'(idx);
    return t;
  endfunction

  // Stop offering input and wait until every expected result is back, then
  // give the block its pipeline depth to go fully idle.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers are only written with the block idle. cfg_valid stays high
  // across the six writes and drops once at the end.
  task automatic write_reg(input cfg_idx_t idx, input logic [COORD_W-1:0] value);
    logic ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  task automatic program_grid(input logic signed [COORD_W-1:0] xl, xh, yl, yh,
                              input logic [7:0] cols, input logic [6:0] rows);
    write_reg(CFG_X_LOWER, xl);
    write_reg(CFG_X_UPPER, xh);
    write_reg(CFG_Y_LOWER, yl);
    write_reg(CFG_Y_UPPER, yh);
    write_reg(CFG_GRID_COLS, {24'd0, cols});
    write_reg(CFG_GRID_ROWS, {25'd0, rows});
    cfg_valid <= 1'b0;
    cur_x_lo = xl;
    cur_x_hi = xh;
    cur_y_lo = yl;
    cur_y_hi = yh;
    cur_cols = (cols == 0) ? 1 : (cols > GRID_MAX_COLS) ? GRID_MAX_COLS : int'(cols);
    cur_rows = (rows == 0) ? 1 : (rows > GRID_MAX_ROWS) ? GRID_MAX_ROWS : int'(rows);
  endtask

  // A coordinate inside [lo, hi), with lo or hi - 1 picked now and then; any value for an empty span.
  function automatic logic signed [COORD_W-1:0] pick_inside(
      input logic signed [COORD_W-1:0] lo, input logic signed [COORD_W-1:0] hi);
    longint unsigned span, draw;
    if (hi <= lo) return $urandom;
    span = longint'(hi) - longint'(lo);
    draw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return lo;
      1: return COORD_W'(longint'(hi) - 1);
      default: return COORD_W'(longint'(lo) + longint'(draw % span));
    endcase
  endfunction

  // Bounds for one axis: full range, unit range, narrow, random, or empty.
  task automatic pick_span(output logic signed [COORD_W-1:0] lo,
                           output logic signed [COORD_W-1:0] hi);
    logic signed [COORD_W-1:0] a, b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 15))
      0: begin
        lo = 32'sh8000_0000;
        hi = 32'sh7FFF_FFFF;
      end
      1: begin
        lo = 0;
        hi = 32'sh0001_0000;
      end
      2, 3, 4, 5: begin
        lo = a >>> 1;
        hi = lo + $urandom_range(1, 4096);
      end
      15: begin
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end
      default: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
  endtask

  // Grid dimension: mostly small so that reads find populated cells.
  function automatic logic [7:0] pick_dim(input int maxv, input int all_ones);
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'(maxv);
      3: return 8'(all_ones);
      4, 5: return 8'($urandom_range(1, maxv));
      default: return 8'($urandom_range(2, 12));
    endcase
  endfunction

  task automatic random_grid();
    logic signed [COORD_W-1:0] xl, xh, yl, yh;
    logic [7:0]                cols, rows;
    pick_span(xl, xh);
    pick_span(yl, yh);
    cols = pick_dim(GRID_MAX_COLS, 255);
    rows = pick_dim(GRID_MAX_ROWS, 127);
    program_grid(xl, xh, yl, yh, cols, rows[6:0]);
  endtask

  // Mostly in-bounds plots; reads mostly aimed at the grid in use. Unused
  // fields carry random noise so every input bit toggles.
  task automatic random_txn();
    in_t t;
    t.command    = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_PLOT;
    t.x_coord    = $urandom;
    t.y_coord    = $urandom;
    t.cell_index = IDX_W'($urandom);
    if (t.command == CMD_PLOT) begin
      if ($urandom_range(0, 7) != 0) begin
        t.x_coord = pick_inside(cur_x_lo, cur_x_hi);
        t.y_coord = pick_inside(cur_y_lo, cur_y_hi);
      end
    end else if ($urandom_range(0, 3) != 0) begin
      t.cell_index = IDX_W'($urandom_range(0, cur_cols * cur_rows - 1));
    end
    send_txn(t);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    end_check     = 1'b0;
    rst_n         = 1'b0;
    idle_en       = 1'b1;
    long_hold_req = 1'b0;
    cur_x_lo      = X_LOWER_RST;
    cur_x_hi      = X_UPPER_RST;
    cur_y_lo      = Y_LOWER_RST;
    cur_y_hi      = Y_UPPER_RST;
    cur_cols      = GRID_COLS_RST;
    cur_rows      = GRID_ROWS_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset bounds, 80x24 grid: corners, exclusive upper edges, extreme
    // coordinates, reads of hit cells, a read past cols*rows, read-after-clear.
    send_txn(plot_txn(0, 0));
    send_txn(plot_txn(65535, 65535));
    send_txn(plot_txn(65535, 0));
    send_txn(plot_txn(-1, 0));
    send_txn(plot_txn(65536, 100));
    send_txn(plot_txn(100, 65536));
    send_txn(plot_txn(32'sh7FFF_FFFF, 32'sh8000_0000));
    send_txn(read_txn(23 * 80));
    send_txn(read_txn(79));
    send_txn(read_txn(8191));
    send_txn(read_txn(23 * 80));

    // Widest span with the largest grid; the offset times scale is widest here.
    drain_results();
    program_grid(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 8'd128, 7'd64);
    send_txn(plot_txn(32'sh8000_0000, 32'sh8000_0000));
    send_txn(plot_txn(32'sh7FFF_FFFE, 32'sh7FFF_FFFE));
    send_txn(plot_txn(32'sh7FFF_FFFF, 0));
    send_txn(read_txn(63 * 128));
    send_txn(read_txn(127));

    // Empty x span and inverted y span: everything dropped; zero grid size.
    drain_results();
    program_grid(5, 5, 100, -100, 8'd0, 7'd0);
    send_txn(plot_txn(5, 5));
    send_txn(plot_txn(0, 0));

    // Grid sizes above the maximum clamp; negative y range.
    drain_results();
    program_grid(0, 32'sh0001_0000, -32'sh0001_0000, 0, 8'd255, 7'd127);
    send_txn(plot_txn(0, -32'sh0001_0000));
    send_txn(plot_txn(65535, -1));
    send_txn(read_txn(63 * 128));
    send_txn(read_txn(127));

    // Zero sizes count as a single cell.
    drain_results();
    program_grid(0, 32'sh0001_0000, 0, 32'sh0001_0000, 8'd0, 7'd0);
    send_txn(plot_txn(32768, 32768));
    send_txn(read_txn(0));

    // Random phases, each under a fresh configuration. One phase starts with
    // a long sink hold-off; one pauses midway until everything is back; the
    // last runs with no idling at all.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      random_grid();
      idle_en = (phase != RANDOM_PHASES - 1);
      if (phase == HOLD_PHASE) long_hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) drain_results();
        random_txn();
      end
    end

    drain_results();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run including the store clear.
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== scatter_subcell_rasterizer.f =====
rtl/core/sscr_pkg.sv
rtl/core/sscr_ram.sv
rtl/core/sscr_div.sv
rtl/core/scatter_subcell_rasterizer.sv
dv/sscr_cell_checker.sv
dv/tb_scatter_subcell_rasterizer.sv
